FILE: sv/pps_pkg.sv
// Shared types, constants and helpers for the polygon plane splitter.
package pps_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int NORMAL_WIDTH = 18;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = DIFF_W + NORMAL_WIDTH;
   localparam int DIST_W = PROD_W + 2;
   localparam int DEN_W  = DIST_W + 1;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam int CSR_IDX_W   = CSR_ADDR_W - CSR_IDX_LSB;

   typedef logic signed [COORD_WIDTH-1:0]  coord_type;
   typedef logic signed [NORMAL_WIDTH-1:0] normal_type;
   typedef logic signed [DIFF_W-1:0]       diff_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [DIST_W-1:0]       dist_type;
   typedef logic        [DIFF_W-1:0]       umag_type;
   typedef logic        [DIST_W-1:0]       dmag_type;
   typedef logic        [DEN_W-1:0]        den_type;

   localparam normal_type NORMAL_ONE = normal_type'(1 << 16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PX = 3'd0,
      CSR_PY = 3'd1,
      CSR_PZ = 3'd2,
      CSR_NX = 3'd3,
      CSR_NY = 3'd4,
      CSR_NZ = 3'd5
   } csr_index_type;

   typedef struct packed {
      coord_type  px;
      coord_type  py;
      coord_type  pz;
      normal_type nx;
      normal_type ny;
      normal_type nz;
   } plane_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      dist_type  sdist;
      logic      fin;
   } entry_type;

   typedef struct packed {
      logic      side;
      coord_type x;
      coord_type y;
      coord_type z;
      logic      is_crossing;
      logic      run_end;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EDGE,
      BK_DIV,
      BK_XF,
      BK_XB,
      BK_VF,
      BK_VB
   } back_state_type;

   function automatic dmag_type dist_mag(dist_type d);
      dist_type neg;
      neg = -d;
      return d[DIST_W-1] ? dmag_type'(neg) : dmag_type'(d);
   endfunction

   function automatic umag_type diff_mag(diff_type d);
      diff_type neg;
      neg = -d;
      return d[DIFF_W-1] ? umag_type'(neg) : umag_type'(d);
   endfunction

endpackage

FILE: sv/pps_req_if.sv
// Vertex input channel.
interface pps_req_if;
   import pps_pkg::*;

   logic      valid;
   logic      ready;
   coord_type vert_x;
   coord_type vert_y;
   coord_type vert_z;
   logic      final_vertex;

   modport source (output valid, vert_x, vert_y, vert_z, final_vertex, input ready);
   modport sink   (input valid, vert_x, vert_y, vert_z, final_vertex, output ready);
endinterface

FILE: sv/pps_rsp_if.sv
// Split-point result channel.
interface pps_rsp_if;
   import pps_pkg::*;

   logic      valid;
   logic      ready;
   logic      side;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      is_crossing;
   logic      run_end;

   modport source (output valid, side, out_x, out_y, out_z, is_crossing, run_end,
                   input ready);
   modport sink   (input valid, side, out_x, out_y, out_z, is_crossing, run_end,
                   output ready);
endinterface

FILE: sv/pps_front.sv
// Front end: takes vertices and computes their signed plane distance in two stages.
module pps_front (
   input  logic                clock,
   input  logic                reset,
   input  pps_pkg::plane_type  plane,
   pps_req_if.sink             req,
   output logic                push_valid,
   output pps_pkg::entry_type  push_data,
   input  logic                push_ready
);
   import pps_pkg::*;

   coord_type  v_in [3];
   coord_type  p_in [3];
   normal_type n_in [3];
   prod_type   prod_in [3];

   logic       s1_vld_ff;
   prod_type   s1_prod_ff [3];
   coord_type  s1_v_ff [3];
   logic       s1_fin_ff;

   logic       s2_vld_ff;
   entry_type  s2_data_ff;
   entry_type  s2_data_in;

   logic       adv1;
   logic       adv2;

   assign adv2      = !s2_vld_ff || push_ready;
   assign adv1      = !s1_vld_ff || adv2;
   assign req.ready = adv1;

   always_comb begin
      v_in[0] = req.vert_x;
      v_in[1] = req.vert_y;
      v_in[2] = req.vert_z;
      p_in[0] = plane.px;
      p_in[1] = plane.py;
      p_in[2] = plane.pz;
      n_in[0] = plane.nx;
      n_in[1] = plane.ny;
      n_in[2] = plane.nz;
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = prod_type'(diff_type'(v_in[i]) - diff_type'(p_in[i]))
                      * prod_type'(n_in[i]);
      end
   end

   always_comb begin
      s2_data_in.x     = s1_v_ff[0];
      s2_data_in.y     = s1_v_ff[1];
      s2_data_in.z     = s1_v_ff[2];
      s2_data_in.sdist = dist_type'(s1_prod_ff[0]) + dist_type'(s1_prod_ff[1])
                         + dist_type'(s1_prod_ff[2]);
      s2_data_in.fin   = s1_fin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (adv1) s1_vld_ff <= req.valid;
         if (adv2) s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req.valid) begin
         s1_prod_ff <= prod_in;
         s1_v_ff    <= v_in;
         s1_fin_ff  <= req.final_vertex;
      end
      if (adv2 && s1_vld_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign push_valid = s2_vld_ff;
   assign push_data  = s2_data_ff;
endmodule

FILE: sv/pps_queue.sv
// Short vertex queue between the front end and the split sequencer.
module pps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pps_pkg::entry_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output pps_pkg::entry_type pop_data,
   input  logic               pop_ready
);
   import pps_pkg::*;

   entry_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end
endmodule

FILE: sv/pps_xdiv.sv
// One lane of floor(|delta| * |da| / den), one bit of |delta| per cycle.
module pps_xdiv (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pps_pkg::umag_type mag_delta,
   input  pps_pkg::dmag_type num_a,
   input  pps_pkg::den_type  den,
   output logic              busy,
   output pps_pkg::umag_type quo
);
   import pps_pkg::*;

   localparam int CNT_W = $clog2(DIFF_W);
   localparam int T_W   = DEN_W + 2;

   logic               busy_ff;
   logic [CNT_W-1:0]   cnt_ff;
   umag_type           bits_ff;
   dmag_type           a_ff;
   den_type            den_ff;
   den_type            rem_ff;
   den_type            rem_in;
   umag_type           quo_ff;
   umag_type           quo_in;
   logic [T_W-1:0]     t_val;
   logic [T_W-1:0]     twice;
   logic [T_W-1:0]     once;

   // Keep quotient and remainder of the partial product: 2R + A stays below 3*den.
   always_comb begin
      once  = T_W'(den_ff);
      twice = once << 1;
      t_val = (T_W'(rem_ff) << 1) + (bits_ff[DIFF_W-1] ? T_W'(a_ff) : '0);
      if (t_val >= twice) begin
         rem_in = den_type'(t_val - twice);
         quo_in = (quo_ff << 1) + umag_type'(2);
      end else if (t_val >= once) begin
         rem_in = den_type'(t_val - once);
         quo_in = (quo_ff << 1) + umag_type'(1);
      end else begin
         rem_in = den_type'(t_val);
         quo_in = quo_ff << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= CNT_W'(DIFF_W - 1);
         bits_ff <= mag_delta;
         a_ff    <= num_a;
         den_ff  <= den;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         bits_ff <= bits_ff << 1;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule

FILE: sv/pps_back.sv
// Split sequencer: walks each edge, computes crossings and emits the side lists.
module pps_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  pps_pkg::entry_type pop_data,
   output logic               pop_ready,
   pps_rsp_if.source          rsp
);
   import pps_pkg::*;

   back_state_type state_ff;
   back_state_type state_in;

   coord_type  first_v_ff [3];
   dist_type   first_d_ff;
   coord_type  ftail_ff [3];
   coord_type  btail_ff [3];
   logic       fne_ff;
   logic       bne_ff;
   logic       await_ff;
   logic       pend2_ff;

   coord_type  ea_ff [3];
   coord_type  eb_ff [3];
   dist_type   eda_ff;
   dist_type   edb_ff;
   logic       elast_ff;
   coord_type  pt_ff [3];
   coord_type  pt_in [3];
   coord_type  pop_v [3];

   logic       rsp_vld_ff;
   result_type rsp_data_ff;

   logic       out_free;
   logic       crossing;
   logic       skip_f;
   logic       skip_b;
   logic       lane_start;
   logic       lanes_busy;
   logic       emit;
   logic       edge_done;
   result_type emit_res;

   logic       lane_busy [3];
   umag_type   lane_quo [3];
   umag_type   lane_mag [3];
   diff_type   delta [3];
   dmag_type   a_mag;
   den_type    den_val;

   assign out_free = !rsp_vld_ff || rsp.ready;
   assign crossing = (eda_ff < 0 && edb_ff > 0) || (eda_ff > 0 && edb_ff < 0);
   assign a_mag    = dist_mag(eda_ff);
   assign den_val  = den_type'(a_mag) + den_type'(dist_mag(edb_ff));
   assign skip_f   = fne_ff && ftail_ff[0] == pt_ff[0] && ftail_ff[1] == pt_ff[1]
                     && ftail_ff[2] == pt_ff[2];
   assign skip_b   = bne_ff && btail_ff[0] == pt_ff[0] && btail_ff[1] == pt_ff[1]
                     && btail_ff[2] == pt_ff[2];
   assign lanes_busy = lane_busy[0] || lane_busy[1] || lane_busy[2];

   assign pop_v[0] = pop_data.x;
   assign pop_v[1] = pop_data.y;
   assign pop_v[2] = pop_data.z;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      assign delta[g]    = diff_type'(eb_ff[g]) - diff_type'(ea_ff[g]);
      assign lane_mag[g] = diff_mag(delta[g]);
      assign pt_in[g]    = coord_type'(diff_type'(ea_ff[g])
                           + (delta[g] < 0 ? -$signed(lane_quo[g]) : $signed(lane_quo[g])));

      pps_xdiv u_xdiv (
         .clock     (clock),
         .reset     (reset),
         .start     (lane_start),
         .mag_delta (lane_mag[g]),
         .num_a     (a_mag),
         .den       (den_val),
         .busy      (lane_busy[g]),
         .quo       (lane_quo[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) state_in = (await_ff && !pop_data.fin) ? BK_IDLE : BK_EDGE;
         end
         BK_EDGE: begin
            if (crossing)         state_in = BK_DIV;
            else if (edb_ff >= 0) state_in = BK_VF;
            else                  state_in = BK_VB;
         end
         BK_DIV: begin
            if (!lanes_busy) state_in = BK_XF;
         end
         BK_XF: begin
            if (skip_f || out_free) state_in = BK_XB;
         end
         BK_XB: begin
            if (skip_b || out_free) state_in = (edb_ff >= 0) ? BK_VF : BK_VB;
         end
         BK_VF: begin
            if (out_free) begin
               if (edb_ff <= 0)   state_in = BK_VB;
               else if (pend2_ff) state_in = BK_EDGE;
               else               state_in = BK_IDLE;
            end
         end
         BK_VB: begin
            if (out_free) state_in = pend2_ff ? BK_EDGE : BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready   = 1'b0;
      lane_start  = 1'b0;
      emit        = 1'b0;
      edge_done   = 1'b0;
      emit_res    = '0;
      emit_res.x  = eb_ff[0];
      emit_res.y  = eb_ff[1];
      emit_res.z  = eb_ff[2];
      case (state_ff)
         BK_IDLE: pop_ready = 1'b1;
         BK_EDGE: lane_start = crossing;
         BK_XF: begin
            emit                 = out_free && !skip_f;
            emit_res.x           = pt_ff[0];
            emit_res.y           = pt_ff[1];
            emit_res.z           = pt_ff[2];
            emit_res.is_crossing = 1'b1;
         end
         BK_XB: begin
            emit                 = out_free && !skip_b;
            emit_res.side        = 1'b1;
            emit_res.x           = pt_ff[0];
            emit_res.y           = pt_ff[1];
            emit_res.z           = pt_ff[2];
            emit_res.is_crossing = 1'b1;
         end
         BK_VF: begin
            emit             = out_free;
            emit_res.run_end = elast_ff && edb_ff > 0;
            edge_done        = out_free && edb_ff > 0;
         end
         BK_VB: begin
            emit             = out_free;
            emit_res.side    = 1'b1;
            emit_res.run_end = elast_ff;
            edge_done        = out_free;
         end
         default: pop_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         await_ff   <= 1'b1;
         pend2_ff   <= 1'b0;
         fne_ff     <= 1'b0;
         bne_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop_ready && pop_valid) begin
            if (await_ff) begin
               fne_ff   <= 1'b0;
               bne_ff   <= 1'b0;
               await_ff <= pop_data.fin;
               pend2_ff <= 1'b0;
            end else begin
               await_ff <= pop_data.fin;
               pend2_ff <= pop_data.fin;
            end
         end
         if (edge_done && pend2_ff) pend2_ff <= 1'b0;
         if (emit && !emit_res.side) fne_ff <= 1'b1;
         if (emit && emit_res.side)  bne_ff <= 1'b1;
         if (emit)          rsp_vld_ff <= 1'b1;
         else if (rsp.ready) rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         eb_ff  <= pop_v;
         edb_ff <= pop_data.sdist;
         if (await_ff) begin
            // Start of polygon: a lone final vertex closes onto itself.
            first_v_ff <= pop_v;
            first_d_ff <= pop_data.sdist;
            ftail_ff   <= '{default: '0};
            btail_ff   <= '{default: '0};
            ea_ff      <= pop_v;
            eda_ff     <= pop_data.sdist;
            elast_ff   <= 1'b1;
         end else begin
            ea_ff    <= eb_ff;
            eda_ff   <= edb_ff;
            elast_ff <= !pop_data.fin;
         end
      end
      // Closing edge: last vertex back to the first one.
      if (edge_done && pend2_ff) begin
         ea_ff    <= eb_ff;
         eda_ff   <= edb_ff;
         eb_ff    <= first_v_ff;
         edb_ff   <= first_d_ff;
         elast_ff <= 1'b1;
      end
      if (state_ff == BK_DIV && !lanes_busy) pt_ff <= pt_in;
      if (emit && !emit_res.side) begin
         ftail_ff[0] <= emit_res.x;
         ftail_ff[1] <= emit_res.y;
         ftail_ff[2] <= emit_res.z;
      end
      if (emit && emit_res.side) begin
         btail_ff[0] <= emit_res.x;
         btail_ff[1] <= emit_res.y;
         btail_ff[2] <= emit_res.z;
      end
      if (emit) rsp_data_ff <= emit_res;
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.side        = rsp_data_ff.side;
   assign rsp.out_x       = rsp_data_ff.x;
   assign rsp.out_y       = rsp_data_ff.y;
   assign rsp.out_z       = rsp_data_ff.z;
   assign rsp.is_crossing = rsp_data_ff.is_crossing;
   assign rsp.run_end     = rsp_data_ff.run_end;
endmodule

FILE: sv/polygon_plane_split.sv
// Top level of the polygon plane splitter: register file, front end, queue, sequencer.
//
//  channel  direction  transaction
//  req_ch   in         one vertex (x, y, z, final_vertex)
//  rsp_ch   out        one emitted point (side, x, y, z, is_crossing, run_end)
//  psel...  in         APB write/read of plane point and normal
//
// The front end computes the distance of each vertex and runs ahead of the
// sequencer through a 2-entry queue. The sequencer fetches a vertex and takes up
// its edge; for a crossing it runs the shift-subtract lanes and emits the crossing
// point to each side unless it repeats that side's last point, then the vertex point.
// Reset is synchronous and clears all control state; a stalled rsp_ch holds the
// sequencer, which in turn fills the queue and drops req_ch.ready.
module polygon_plane_split (
   input  logic                              clock,
   input  logic                              reset,
   pps_req_if.sink                           req_ch,
   pps_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pps_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pps_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pps_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import pps_pkg::*;

   plane_type     plane_ff;
   csr_index_type csr_idx;
   logic          csr_wr;

   logic          push_valid;
   entry_type     push_data;
   logic          push_ready;
   logic          pop_valid;
   entry_type     pop_data;
   logic          pop_ready;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_W-1:CSR_IDX_LSB]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '{px: '0, py: '0, pz: '0, nx: '0, ny: '0, nz: NORMAL_ONE};
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_PX: plane_ff.px <= coord_type'($signed(pwdata));
            CSR_PY: plane_ff.py <= coord_type'($signed(pwdata));
            CSR_PZ: plane_ff.pz <= coord_type'($signed(pwdata));
            CSR_NX: plane_ff.nx <= normal_type'($signed(pwdata));
            CSR_NY: plane_ff.ny <= normal_type'($signed(pwdata));
            CSR_NZ: plane_ff.nz <= normal_type'($signed(pwdata));
            default: plane_ff <= plane_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_PX:  prdata = CSR_DATA_W'(plane_ff.px);
         CSR_PY:  prdata = CSR_DATA_W'(plane_ff.py);
         CSR_PZ:  prdata = CSR_DATA_W'(plane_ff.pz);
         CSR_NX:  prdata = CSR_DATA_W'(plane_ff.nx);
         CSR_NY:  prdata = CSR_DATA_W'(plane_ff.ny);
         CSR_NZ:  prdata = CSR_DATA_W'(plane_ff.nz);
         default: prdata = '0;
      endcase
   end

   pps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .plane      (plane_ff),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   pps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   pps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_ch)
   );
endmodule

FILE: sv/pps_checker.sv
// Port-level checks on the result channel, bound to the top level.
module pps_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      side,
   input pps_pkg::coord_type        out_x,
   input pps_pkg::coord_type        out_y,
   input pps_pkg::coord_type        out_z,
   input logic                      is_crossing,
   input logic                      run_end
);
   import pps_pkg::*;

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(side) && $stable(out_x) && $stable(out_y)
         && $stable(out_z) && $stable(is_crossing) && $stable(run_end))
      else $error("result changed while stalled");

   a_cross_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(is_crossing && run_end))
      else $error("crossing point flagged as last of a vertex");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind polygon_plane_split pps_checker u_pps_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .side        (rsp_ch.side),
   .out_x       (rsp_ch.out_x),
   .out_y       (rsp_ch.out_y),
   .out_z       (rsp_ch.out_z),
   .is_crossing (rsp_ch.is_crossing),
   .run_end     (rsp_ch.run_end)
);
